### design/kmpm_pkg.sv
// ---------------------------------------------------------------------------
// kmpm_pkg
// Shared types for the KMP byte-stream matcher: item op codes, the queued
// item record and the back-end sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmpm_pkg;

    typedef enum logic [1:0] {
        OP_PAT_APPEND,
        OP_PAT_RESTART,
        OP_TXT,
        OP_TXT_RESTART
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

### design/kmpm_ram.sv
// ---------------------------------------------------------------------------
// kmpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/kmpm_front.sv
// ---------------------------------------------------------------------------
// kmpm_front
// Input side: accepts items, tags each with its op code and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmpm_front
    import kmpm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic       s_start_new,
    input  logic [7:0] s_data_byte,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    localparam int QDEPTH = 2;

    item_t      mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      in_item;
    logic       push, pop;

    always_comb begin
        unique case ({s_kind, s_start_new})
            2'b00:   in_item.op = OP_PAT_APPEND;
            2'b01:   in_item.op = OP_PAT_RESTART;
            2'b10:   in_item.op = OP_TXT;
            default: in_item.op = OP_TXT_RESTART;
        endcase
        in_item.data = s_data_byte;
    end

    assign s_ready = (count_reg != 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QDEPTH))
        else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(QDEPTH)) && !pop |=> (count_reg == 2'(QDEPTH)))
        else $error("full queue changed without a pop");
    a_empty_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

### design/kmpm_back.sv
// ---------------------------------------------------------------------------
// kmpm_back
// Execution side: builds failure links as pattern bytes arrive and walks
// them for each text byte, one link read per cycle; owns the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmpm_back
    import kmpm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int POSITION_BITS = 32,
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_match_found,
    output logic [31:0] m_match_start,
    output logic        m_no_pattern
);

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PATTERN);

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [7:0]               byte_reg, byte_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic [LEN_W-1:0]         plen_reg, plen_next;
    logic [IDX_W-1:0]         pref_reg, pref_next;
    logic [IDX_W-1:0]         matched_reg, matched_next;
    logic [POSITION_BITS-1:0] tidx_reg, tidx_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     found_reg, found_next;
    logic [31:0]              start_reg, start_next;
    logic                     nopat_reg, nopat_next;

    logic [7:0]               p_rdata;
    logic [IDX_W-1:0]         f_rdata;
    logic [IDX_W-1:0]         rd_k;
    logic                     we;
    logic [IDX_W-1:0]         wr_addr;
    logic [7:0]               p_wdata;
    logic [IDX_W-1:0]         f_wdata;

    logic                     out_free, out_load, pop, go_walk;
    logic                     hit, step, is_match, restart;
    logic [IDX_W-1:0]         k_fin;
    logic [LEN_W-1:0]         m_len, len_eff;
    logic [IDX_W-1:0]         pref_eff, matched_eff;
    logic [POSITION_BITS-1:0] tidx_eff, tidx_inc, start_pos;

    kmpm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (p_wdata),
        .raddr (rd_k),
        .rdata (p_rdata)
    );

    // link[k-1] is read alongside pattern[k]; the value is unused when k is 0
    kmpm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_link_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (f_wdata),
        .raddr (rd_k - IDX_W'(1)),
        .rdata (f_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign hit      = (p_rdata == byte_reg);
    assign step     = (k_reg != '0) && !hit;
    assign k_fin    = hit ? k_reg + IDX_W'(1) : k_reg;
    assign m_len    = LEN_W'(k_reg) + LEN_W'(hit);
    assign is_match = (m_len == plen_reg);
    assign start_pos = tidx_reg - POSITION_BITS'(k_reg);

    always_comb begin
        restart     = (q_item.op == OP_PAT_RESTART) || (q_item.op == OP_TXT_RESTART);
        len_eff     = restart ? '0 : plen_reg;
        pref_eff    = restart ? '0 : pref_reg;
        matched_eff = restart ? '0 : matched_reg;
        tidx_eff    = restart ? '0 : tidx_reg;
    end

    // saturating increment of the position feeding this text byte
    always_comb begin
        logic [POSITION_BITS-1:0] base;
        base     = (state_reg == ST_IDLE) ? tidx_eff : tidx_reg;
        tidx_inc = (base == '1) ? base : base + POSITION_BITS'(1);
    end

    // datapath and handshake outputs
    always_comb begin
        q_ready      = 1'b0;
        pop          = 1'b0;
        go_walk      = 1'b0;
        op_next      = op_reg;
        byte_next    = byte_reg;
        k_next       = k_reg;
        plen_next    = plen_reg;
        pref_next    = pref_reg;
        matched_next = matched_reg;
        tidx_next    = tidx_reg;
        rd_k         = k_reg;
        we           = 1'b0;
        wr_addr      = plen_reg[IDX_W-1:0];
        p_wdata      = byte_reg;
        f_wdata      = k_fin;
        out_load     = 1'b0;
        found_next   = found_reg;
        start_next   = start_reg;
        nopat_next   = nopat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = (q_item.op == OP_PAT_APPEND) || (q_item.op == OP_PAT_RESTART)
                          || out_free;
                pop     = q_valid && q_ready;
                if (pop) begin
                    op_next   = q_item.op;
                    byte_next = q_item.data;
                    unique case (q_item.op)
                        OP_PAT_APPEND, OP_PAT_RESTART: begin
                            matched_next = '0;
                            plen_next    = len_eff;
                            pref_next    = pref_eff;
                            if (len_eff == FULL_LEN) begin
                                // pattern full: byte dropped
                            end else if (len_eff == '0) begin
                                we        = 1'b1;
                                wr_addr   = '0;
                                p_wdata   = q_item.data;
                                f_wdata   = '0;
                                plen_next = LEN_W'(1);
                                pref_next = '0;
                            end else begin
                                k_next  = pref_eff;
                                rd_k    = pref_eff;
                                go_walk = 1'b1;
                            end
                        end
                        OP_TXT, OP_TXT_RESTART: begin
                            if (plen_reg == '0) begin
                                out_load     = 1'b1;
                                found_next   = 1'b0;
                                start_next   = '0;
                                nopat_next   = 1'b1;
                                matched_next = '0;
                                tidx_next    = tidx_inc;
                            end else begin
                                tidx_next = tidx_eff;
                                k_next    = matched_eff;
                                rd_k      = matched_eff;
                                go_walk   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (step) begin
                    k_next = f_rdata;
                    rd_k   = f_rdata;
                end else if (op_reg == OP_PAT_APPEND || op_reg == OP_PAT_RESTART) begin
                    we        = 1'b1;
                    pref_next = k_fin;
                    plen_next = plen_reg + LEN_W'(1);
                end else begin
                    out_load     = 1'b1;
                    found_next   = is_match;
                    start_next   = is_match ? 32'(start_pos) : '0;
                    nopat_next   = 1'b0;
                    matched_next = is_match ? '0 : k_fin;
                    tidx_next    = tidx_inc;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: state_next = go_walk ? ST_WALK : ST_IDLE;
            ST_WALK: state_next = step ? ST_WALK : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            plen_reg    <= '0;
            pref_reg    <= '0;
            matched_reg <= '0;
            tidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            pref_reg    <= pref_next;
            matched_reg <= matched_next;
            tidx_reg    <= tidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        byte_reg  <= byte_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        start_reg <= start_next;
        nopat_reg <= nopat_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_match_found = found_reg;
    assign m_match_start = start_reg;
    assign m_no_pattern  = nopat_reg;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");
    a_walk_in_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (LEN_W'(k_reg) < plen_reg))
        else $error("walk index beyond stored pattern");
    a_matched_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (matched_reg == '0) || (LEN_W'(matched_reg) < plen_reg))
        else $error("matched length not below pattern length");
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(found_reg && nopat_reg))
        else $error("match and no-pattern both flagged");
    a_no_pop_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !pop)
        else $error("item taken while walking");
`endif

endmodule

### design/kmp_byte_stream_matcher.sv
// A text byte passes from the input queue into the back end's item registers and then into the
// result register, with a further ST_WALK pass for each failure-link step of its fallback walk.
// The back end takes no new item while it walks; a pattern byte into an empty or full pattern
// and a text byte with no pattern are handled in ST_IDLE without a walk.
// The result register and a 2-entry input queue let each side stall independently.
// Reset (aresetn, synchronous, active low) clears lengths, text index and handshake state.
// ---------------------------------------------------------------------------
// kmp_byte_stream_matcher
// Knuth-Morris-Pratt matcher over a byte stream, non-overlapping matches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmp_byte_stream_matcher
    import kmpm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic        s_start_new,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_match_found,
    output logic [31:0] m_match_start,
    output logic        m_no_pattern
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    kmpm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_start_new (s_start_new),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    kmpm_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .m_no_pattern  (m_no_pattern)
    );

endmodule
